FILE: src/bcoc_pkg.sv
// Shared types and constants for the box-count occupancy counter.
// No dependencies; used by every module under src except bcoc_mark_mem.
`timescale 1ns / 1ps

package bcoc_pkg;

  localparam int unsigned REG_W     = 11;
  localparam int unsigned NUM_W     = 6;
  localparam int unsigned PIX_W     = 8;
  localparam int unsigned SIZE_W    = 7;
  localparam int unsigned COUNT_W   = 19;
  localparam int unsigned BOX_POS_W = 6;
  localparam int unsigned ADDR_W    = 4;
  localparam int unsigned DATA_W    = 32;

  localparam logic [PIX_W-1:0]   OCC_VALUE = 8'd255;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 19'h7FFFF;

  typedef enum logic [1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_SIZES  = 2'd2
  } reg_idx_e;

  // Per-pixel control from the position tracker to the lanes.
  typedef struct packed {
    logic step;
    logic occ;
    logic row_end;
    logic frame_end;
    logic clear;
  } step_t;

endpackage

FILE: src/bcoc_mark_mem.sv
// Column mark memory: one word per region column, one bit per box size.
// Synchronous read: the read data is registered. Depends on nothing.
`timescale 1ns / 1ps

module bcoc_mark_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/bcoc_lanes.sv
// One lane per box size: position in the box grid, box accumulators, counts.
// Depends on bcoc_pkg; reads and writes back the column mark word.
`timescale 1ns / 1ps

module bcoc_lanes #(
  parameter int unsigned LANES = 32
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  bcoc_pkg::step_t                          ctl_i,
  input  logic [LANES-1:0]                         rdata_i,
  output logic [LANES-1:0]                         wdata_o,
  output logic [LANES-1:0][bcoc_pkg::COUNT_W-1:0]  cnt_next_o
);

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    localparam logic [bcoc_pkg::BOX_POS_W-1:0] SIZE_M1 = bcoc_pkg::BOX_POS_W'(2 * k + 1);

    logic [bcoc_pkg::BOX_POS_W-1:0] cib_q, cib_d, rib_q, rib_d;
    logic                           accp_q, accp_d, accc_q, accc_d;
    logic [bcoc_pkg::COUNT_W-1:0]   cnt_q, cnt_d, cnt_upd;
    logic                           mem_bit, prior, cur, box_end;

    always_comb begin
      // band start: stored column marks belong to an older band
      mem_bit = rdata_i[k] & (rib_q != '0);
      prior   = accp_q | mem_bit;
      cur     = accc_q | ctl_i.occ;
      box_end = ctl_i.row_end | (cib_q == SIZE_M1);
      cnt_upd = cnt_q;
      if (ctl_i.step && box_end && cur && !prior && cnt_q != bcoc_pkg::COUNT_MAX) begin
        cnt_upd = cnt_q + 1'b1;
      end

      cib_d  = cib_q;
      rib_d  = rib_q;
      accp_d = accp_q;
      accc_d = accc_q;
      cnt_d  = cnt_q;
      if (ctl_i.clear) begin
        cib_d  = '0;
        rib_d  = '0;
        accp_d = 1'b0;
        accc_d = 1'b0;
        cnt_d  = '0;
      end else if (ctl_i.step) begin
        cnt_d  = ctl_i.frame_end ? '0 : cnt_upd;
        accp_d = box_end ? 1'b0 : prior;
        accc_d = box_end ? 1'b0 : cur;
        if (ctl_i.frame_end) begin
          cib_d = '0;
          rib_d = '0;
        end else if (ctl_i.row_end) begin
          cib_d = '0;
          rib_d = (rib_q == SIZE_M1) ? '0 : rib_q + 1'b1;
        end else begin
          cib_d = (cib_q == SIZE_M1) ? '0 : cib_q + 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        cib_q  <= '0;
        rib_q  <= '0;
        accp_q <= 1'b0;
        accc_q <= 1'b0;
        cnt_q  <= '0;
      end else begin
        cib_q  <= cib_d;
        rib_q  <= rib_d;
        accp_q <= accp_d;
        accc_q <= accc_d;
        cnt_q  <= cnt_d;
      end
    end

    assign wdata_o[k]    = mem_bit | ctl_i.occ;
    assign cnt_next_o[k] = cnt_upd;
  end

endmodule

FILE: src/bcoc_emit.sv
// Result emitter: snapshots the counts at frame end and streams one
// transaction per box size through a registered output. Depends on bcoc_pkg.
`timescale 1ns / 1ps

module bcoc_emit #(
  parameter int unsigned LANES = 32
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start_i,
  input  logic [bcoc_pkg::NUM_W-1:0]              num_i,
  input  logic [LANES-1:0][bcoc_pkg::COUNT_W-1:0] cnt_i,
  output logic                                    busy_o,
  output logic                                    valid_o,
  input  logic                                    ready_i,
  output logic [bcoc_pkg::SIZE_W-1:0]             box_size_o,
  output logic [bcoc_pkg::COUNT_W-1:0]            box_count_o,
  output logic                                    last_o
);

  localparam int unsigned IW = (LANES > 1) ? $clog2(LANES) : 1;

  logic [LANES-1:0][bcoc_pkg::COUNT_W-1:0] snap_q;
  logic                                    busy_q, valid_q, last_q;
  logic [IW-1:0]                           idx_q;
  logic [bcoc_pkg::NUM_W-1:0]              num_q, idx_p1;
  logic [bcoc_pkg::SIZE_W-1:0]             size_q;
  logic [bcoc_pkg::COUNT_W-1:0]            count_q;
  logic                                    load, is_last;

  assign load    = busy_q && (!valid_q || ready_i);
  assign idx_p1  = bcoc_pkg::NUM_W'(idx_q) + 1'b1;
  assign is_last = (idx_p1 == num_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
      idx_q   <= '0;
      num_q   <= '0;
    end else begin
      if (start_i) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
        num_q  <= num_i;
      end else if (load) begin
        busy_q <= !is_last;
        idx_q  <= idx_q + 1'b1;
      end
      if (load) begin
        valid_q <= 1'b1;
      end else if (ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      snap_q <= cnt_i;
    end
    if (load) begin
      size_q  <= bcoc_pkg::SIZE_W'({idx_p1, 1'b0});
      count_q <= snap_q[idx_q];
      last_q  <= is_last;
    end
  end

  assign busy_o      = busy_q;
  assign valid_o     = valid_q;
  assign box_size_o  = size_q;
  assign box_count_o = count_q;
  assign last_o      = last_q;

endmodule

FILE: src/box_count_occupancy_counter.sv
// Top level of the box-count occupancy counter: APB registers, raster
// position tracking, handshakes. Uses bcoc_pkg, bcoc_mark_mem, bcoc_lanes, bcoc_emit.
`timescale 1ns / 1ps

// Channel   Direction  Handshake                      Payload
// pixel     in         pixel_valid_i / pixel_ready_o   pixel_i (8b)
// result    out        result_valid_o / result_ready_i box_size_o, box_count_o, last_of_run_o
// config    in         APB psel/penable/pwrite, pready region_width, region_height, num_box_sizes
//
// One pixel per cycle while pixel_ready_o is high. Each lane (box size) reads the column
// mark word via a registered read one column ahead and writes it back as the pixel is taken.
// The last pixel of a frame queues num_box_sizes results, one per cycle as the
// result side takes them; a following last pixel waits until that run is out.
// Reset is asynchronous; the mark memory needs no clearing pass, since marks
// read in the first row of a band are ignored. A write to width, height or sizes restarts the frame.

module box_count_occupancy_counter #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024,
  parameter int unsigned MAX_SIZES  = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel stream
  input  logic                                pixel_valid_i,
  output logic                                pixel_ready_o,
  input  logic [bcoc_pkg::PIX_W-1:0]          pixel_i,
  // result stream
  output logic                                result_valid_o,
  input  logic                                result_ready_i,
  output logic [bcoc_pkg::SIZE_W-1:0]         box_size_o,
  output logic [bcoc_pkg::COUNT_W-1:0]        box_count_o,
  output logic                                last_of_run_o,
  // APB register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [bcoc_pkg::ADDR_W-1:0]         paddr,
  input  logic [bcoc_pkg::DATA_W-1:0]         pwdata,
  output logic [bcoc_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT);
  localparam logic [12:0] MAXW = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH = 13'(MAX_HEIGHT);
  localparam logic [bcoc_pkg::NUM_W-1:0] MAXS = bcoc_pkg::NUM_W'(MAX_SIZES);

  // ---------------- configuration registers ----------------
  logic [bcoc_pkg::REG_W-1:0] width_q, height_q;
  logic [bcoc_pkg::NUM_W-1:0] sizes_q;
  logic                       cfg_wr;
  bcoc_pkg::reg_idx_e         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = bcoc_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= bcoc_pkg::REG_W'(1024);
      height_q <= bcoc_pkg::REG_W'(1024);
      sizes_q  <= bcoc_pkg::NUM_W'(20);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        bcoc_pkg::REG_WIDTH:  width_q  <= pwdata[bcoc_pkg::REG_W-1:0];
        bcoc_pkg::REG_HEIGHT: height_q <= pwdata[bcoc_pkg::REG_W-1:0];
        bcoc_pkg::REG_SIZES:  sizes_q  <= pwdata[bcoc_pkg::NUM_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      bcoc_pkg::REG_WIDTH:  prdata = bcoc_pkg::DATA_W'(width_q);
      bcoc_pkg::REG_HEIGHT: prdata = bcoc_pkg::DATA_W'(height_q);
      bcoc_pkg::REG_SIZES:  prdata = bcoc_pkg::DATA_W'(sizes_q);
      default:              prdata = '0;
    endcase
  end

  // any write to a listed register restarts the frame
  logic cfg_clear;
  assign cfg_clear = cfg_wr && (cfg_idx == bcoc_pkg::REG_WIDTH ||
                                cfg_idx == bcoc_pkg::REG_HEIGHT ||
                                cfg_idx == bcoc_pkg::REG_SIZES);

  // clamped region and size count
  logic [12:0]                w_ext, h_ext, w_eff, h_eff;
  logic [CW-1:0]              w_last;
  logic [RW-1:0]              h_last;
  logic [bcoc_pkg::NUM_W-1:0] n_eff;

  always_comb begin
    w_ext = 13'(width_q);
    h_ext = 13'(height_q);
    w_eff = (w_ext < 13'd2) ? 13'd2 : ((w_ext > MAXW) ? MAXW : w_ext);
    h_eff = (h_ext < 13'd2) ? 13'd2 : ((h_ext > MAXH) ? MAXH : h_ext);
    w_last = CW'(w_eff - 13'd1);
    h_last = RW'(h_eff - 13'd1);
    n_eff = (sizes_q == '0) ? bcoc_pkg::NUM_W'(1) : ((sizes_q > MAXS) ? MAXS : sizes_q);
  end

  // ---------------- raster position ----------------
  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic          row_end, frame_end, accept, emit_busy;

  assign row_end       = (col_q == w_last);
  assign frame_end     = row_end && (row_q == h_last);
  // a last pixel waits while the previous run is still being streamed
  assign pixel_ready_o = !(frame_end && emit_busy);
  assign accept        = pixel_valid_i && pixel_ready_o;

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (cfg_clear) begin
      col_d = '0;
      row_d = '0;
    end else if (accept) begin
      if (frame_end) begin
        col_d = '0;
        row_d = '0;
      end else if (row_end) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // ---------------- lanes and mark memory ----------------
  bcoc_pkg::step_t                              ctl;
  logic [MAX_SIZES-1:0]                         mark_rdata, mark_wdata;
  logic [MAX_SIZES-1:0][bcoc_pkg::COUNT_W-1:0] cnt_next;

  assign ctl.step      = accept;
  assign ctl.occ       = (pixel_i == bcoc_pkg::OCC_VALUE);
  assign ctl.row_end   = row_end;
  assign ctl.frame_end = frame_end;
  assign ctl.clear     = cfg_clear;

  // read address runs one pixel ahead; it matches the write address in a write
  // cycle only when a register write restarts the frame at column zero
  bcoc_mark_mem #(
    .DEPTH (MAX_WIDTH),
    .WIDTH (MAX_SIZES)
  ) u_mark_mem (
    .clk_i   (clk_i),
    .we_i    (accept),
    .waddr_i (col_q),
    .wdata_i (mark_wdata),
    .raddr_i (col_d),
    .rdata_o (mark_rdata)
  );

  bcoc_lanes #(
    .LANES (MAX_SIZES)
  ) u_lanes (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (ctl),
    .rdata_i    (mark_rdata),
    .wdata_o    (mark_wdata),
    .cnt_next_o (cnt_next)
  );

  bcoc_emit #(
    .LANES (MAX_SIZES)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept && frame_end),
    .num_i       (n_eff),
    .cnt_i       (cnt_next),
    .busy_o      (emit_busy),
    .valid_o     (result_valid_o),
    .ready_i     (result_ready_i),
    .box_size_o  (box_size_o),
    .box_count_o (box_count_o),
    .last_o      (last_of_run_o)
  );

`ifndef ASSERT_OFF
  // a new run never starts on top of one still streaming
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_end) |-> !emit_busy)
    else $error("run started while emitter busy");

  // the column stays inside the region
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_last)
    else $error("column beyond region");

  // the pixel after a last pixel is the first of a fresh frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_end) |=> (col_q == '0 && row_q == '0))
    else $error("frame did not restart");
`endif

endmodule
